[sv/gmt_pkg.sv]
// package: shared constants and types for the membership table
`timescale 1ns / 1ps
package gmt_pkg;
  localparam int unsigned TableDepth = 32;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] FuncReport = 2'd0;
  localparam logic [1:0] FuncTick = 2'd1;
  localparam logic [1:0] FuncList = 2'd2;

  localparam logic [2:0] KindAdded = 3'd0;
  localparam logic [2:0] KindRefreshed = 3'd1;
  localparam logic [2:0] KindIgnored = 3'd2;
  localparam logic [2:0] KindDropped = 3'd3;
  localparam logic [2:0] KindFailed = 3'd4;
  localparam logic [2:0] KindRemoved = 3'd5;
  localparam logic [2:0] KindList = 3'd6;
  localparam logic [2:0] KindDone = 3'd7;

  localparam logic [1:0] RegSelfId = 2'd0;
  localparam logic [1:0] RegSelfPort = 2'd1;
  localparam logic [1:0] RegFailTimeout = 2'd2;
  localparam logic [1:0] RegRemoveDelay = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input beat, clear scan
    logic rd;        // issue read of slot at scan index
    logic eval;      // evaluate read data of current slot
    logic finish;    // build final result of report
    logic tick_inc;  // advance local heartbeat
  } gmt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_end;  // last slot issued
    logic hit;       // known member found during scan, or report is about self
    logic emit;      // current evaluation produced a result
  } gmt_sts_t;
endpackage

[sv/gmt_datapath.sv]
// datapath: slot memory, per-slot flags, scan and result building
`timescale 1ns / 1ps
module gmt_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gmt_pkg::gmt_cmd_t       cmd_i,
  output gmt_pkg::gmt_sts_t       sts_o,
  input  logic [1:0]              func_i,
  input  logic [31:0]             member_id_i,
  input  logic [15:0]             member_port_i,
  input  logic [31:0]             member_heartbeat_i,
  input  logic [31:0]             self_id_i,
  input  logic [15:0]             self_port_i,
  input  logic [7:0]              fail_timeout_i,
  input  logic [7:0]              remove_delay_i,
  output logic [2:0]              res_kind_o,
  output logic [31:0]             res_id_o,
  output logic [15:0]             res_port_o,
  output logic [31:0]             res_heartbeat_o,
  output logic [31:0]             local_hb_o
);
  localparam int unsigned D = gmt_pkg::TableDepth;
  localparam int unsigned SW = gmt_pkg::SlotW;
  localparam int unsigned CW = gmt_pkg::CntW;

  logic [31:0] mem_id [D];
  logic [15:0] mem_port [D];
  logic [31:0] mem_hb [D];
  logic [31:0] mem_seen [D];
  logic [7:0]  mem_cd [D];
  logic [D-1:0] valid_q, failed_q;

  logic [31:0] rd_id_q, rd_hb_q, rd_seen_q;
  logic [15:0] rd_port_q;
  logic [7:0]  rd_cd_q;
  logic        rd_valid_q, rd_failed_q;
  logic [SW-1:0] rd_slot_q;

  logic [CW-1:0] idx_q;
  logic [1:0]  func_q;
  logic [31:0] id_q, hb_q, lhb_q;
  logic [15:0] port_q;
  logic        hit_q, free_found_q;
  logic [SW-1:0] free_slot_q;

  logic is_self, match, stale, emit;
  logic [31:0] age;

  assign is_self = (id_q == self_id_i) && (port_q == self_port_i);
  assign match = rd_valid_q && (rd_id_q == id_q) && (rd_port_q == port_q);
  assign age = lhb_q - rd_seen_q;
  assign stale = age > {24'd0, fail_timeout_i};

  always_comb begin
    emit = 1'b0;
    if (cmd_i.eval) begin
      case (func_q)
        gmt_pkg::FuncReport: emit = match && !hit_q && !is_self;
        gmt_pkg::FuncTick:   emit = rd_valid_q && (rd_failed_q ? (rd_cd_q <= 8'd1) : stale);
        gmt_pkg::FuncList:   emit = rd_valid_q && !rd_failed_q;
        default:             emit = 1'b0;
      endcase
    end
  end

  assign sts_o.scan_end = (idx_q == CW'(D));
  assign sts_o.hit = hit_q || is_self;
  assign sts_o.emit = emit;
  assign local_hb_o = lhb_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      failed_q <= '0;
      lhb_q <= '0;
      idx_q <= '0;
      hit_q <= 1'b0;
      free_found_q <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_failed_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        hit_q <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (cmd_i.tick_inc) lhb_q <= lhb_q + 32'd1;
      if (cmd_i.rd) begin
        idx_q <= idx_q + CW'(1);
        rd_valid_q <= valid_q[idx_q[SW-1:0]];
        rd_failed_q <= failed_q[idx_q[SW-1:0]];
      end
      if (cmd_i.eval) begin
        case (func_q)
          gmt_pkg::FuncReport: begin
            if (!is_self && !hit_q) begin
              if (match) begin
                hit_q <= 1'b1;
                if (rd_hb_q < hb_q) failed_q[rd_slot_q] <= 1'b0;
              end else if (!rd_valid_q && !free_found_q) begin
                free_found_q <= 1'b1;
              end
            end
          end
          gmt_pkg::FuncTick: begin
            if (rd_valid_q) begin
              if (!rd_failed_q && stale) failed_q[rd_slot_q] <= 1'b1;
              else if (rd_failed_q && rd_cd_q <= 8'd1) begin
                valid_q[rd_slot_q] <= 1'b0;
                failed_q[rd_slot_q] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.finish && !is_self && !hit_q && free_found_q) begin
        valid_q[free_slot_q] <= 1'b1;
        failed_q[free_slot_q] <= 1'b0;
      end
    end
  end

  // memories and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      id_q <= member_id_i;
      port_q <= member_port_i;
      hb_q <= member_heartbeat_i;
    end
    if (cmd_i.rd) begin
      rd_id_q <= mem_id[idx_q[SW-1:0]];
      rd_port_q <= mem_port[idx_q[SW-1:0]];
      rd_hb_q <= mem_hb[idx_q[SW-1:0]];
      rd_seen_q <= mem_seen[idx_q[SW-1:0]];
      rd_cd_q <= mem_cd[idx_q[SW-1:0]];
      rd_slot_q <= idx_q[SW-1:0];
    end
    if (cmd_i.eval) begin
      res_id_o <= rd_id_q;
      res_port_o <= rd_port_q;
      res_heartbeat_o <= rd_hb_q;
      case (func_q)
        gmt_pkg::FuncReport: begin
          if (!is_self && !hit_q) begin
            if (match) begin
              if (rd_hb_q < hb_q) begin
                mem_hb[rd_slot_q] <= hb_q;
                mem_seen[rd_slot_q] <= lhb_q;
                mem_cd[rd_slot_q] <= 8'd0;
                res_kind_o <= gmt_pkg::KindRefreshed;
                res_heartbeat_o <= hb_q;
              end else begin
                res_kind_o <= gmt_pkg::KindIgnored;
              end
            end else if (!rd_valid_q && !free_found_q) begin
              free_slot_q <= rd_slot_q;
            end
          end
        end
        gmt_pkg::FuncTick: begin
          if (rd_failed_q) begin
            res_kind_o <= gmt_pkg::KindRemoved;
            if (rd_cd_q > 8'd1) mem_cd[rd_slot_q] <= rd_cd_q - 8'd1;
          end else begin
            res_kind_o <= gmt_pkg::KindFailed;
            if (stale) mem_cd[rd_slot_q] <= remove_delay_i;
          end
        end
        default: res_kind_o <= gmt_pkg::KindList;
      endcase
    end
    if (cmd_i.finish && !hit_q) begin
      res_id_o <= id_q;
      res_port_o <= port_q;
      res_heartbeat_o <= hb_q;
      if (is_self) res_kind_o <= gmt_pkg::KindIgnored;
      else if (free_found_q) begin
        res_kind_o <= gmt_pkg::KindAdded;
        mem_id[free_slot_q] <= id_q;
        mem_port[free_slot_q] <= port_q;
        mem_hb[free_slot_q] <= hb_q;
        mem_seen[free_slot_q] <= lhb_q;
        mem_cd[free_slot_q] <= 8'd0;
      end else res_kind_o <= gmt_pkg::KindDropped;
    end
  end
endmodule

[sv/gmt_ctrl.sv]
// controller: sequences scan, result beats and the done beat
`timescale 1ns / 1ps
module gmt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              last_o,
  output logic              done_sel_o,
  output gmt_pkg::gmt_cmd_t cmd_o,
  input  gmt_pkg::gmt_sts_t sts_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_WAIT, S_FIN, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, last_q, done_q, is_report_q;
  logic out_valid_d, last_d, done_d, is_report_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign out_valid_o = out_valid_q;
  assign last_o = last_q;
  assign done_sel_o = done_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    last_d = last_q;
    done_d = done_q;
    is_report_d = is_report_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i && out_free) begin
        cmd_o.load = 1'b1;
        cmd_o.tick_inc = (func_i == gmt_pkg::FuncTick);
        is_report_d = (func_i == gmt_pkg::FuncReport);
        state_d = S_READ;
      end
      S_READ: if (sts_i.scan_end) begin
        state_d = is_report_q ? S_FIN : S_DONE;
      end else begin
        cmd_o.rd = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: if (out_free) begin
        cmd_o.eval = 1'b1;
        if (sts_i.emit) begin
          out_valid_d = 1'b1;
          last_d = is_report_q;
          done_d = 1'b0;
          state_d = is_report_q ? S_IDLE : S_READ;
        end else state_d = S_READ;
      end
      S_FIN: if (out_free) begin
        cmd_o.finish = 1'b1;
        out_valid_d = 1'b1;
        last_d = 1'b1;
        done_d = 1'b0;
        state_d = S_IDLE;
      end
      S_DONE: if (out_free) begin
        out_valid_d = 1'b1;
        last_d = 1'b1;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
      is_report_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      last_q <= last_d;
      done_q <= done_d;
      is_report_q <= is_report_d;
    end
  end
endmodule

[sv/gossip_membership_table.sv]
// top level: gossip heartbeat membership table with apb register port
`timescale 1ns / 1ps
// Membership table of 32 slots. Every input beat (report, tick or listing)
// walks the slot memory once, reading a slot and then evaluating it before
// the next read; an evaluation waits while the output register is full, and
// a report ends early at the matching slot. Results leave through a single
// output register; the next beat is taken only once the controller is idle
// and that register is free. Ticks and listings end with a done beat
// carrying the local heartbeat. Registers at byte addresses 0 self_id,
// 4 self_port, 8 fail_timeout, 12 remove_delay.
module gossip_membership_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] member_id_i,
  input  logic [15:0] member_port_i,
  input  logic [31:0] member_heartbeat_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_port_o,
  output logic [31:0] out_heartbeat_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  gmt_pkg::gmt_cmd_t cmd;
  gmt_pkg::gmt_sts_t sts;
  logic [31:0] self_id_q;
  logic [15:0] self_port_q;
  logic [7:0]  fail_timeout_q, remove_delay_q;
  logic [2:0]  res_kind;
  logic [31:0] res_id, res_hb, local_hb;
  logic [15:0] res_port;
  logic        done_sel;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // register file, written on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q <= '0;
      self_port_q <= '0;
      fail_timeout_q <= 8'd5;
      remove_delay_q <= 8'd20;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        gmt_pkg::RegSelfId:      self_id_q <= pwdata;
        gmt_pkg::RegSelfPort:    self_port_q <= pwdata[15:0];
        gmt_pkg::RegFailTimeout: fail_timeout_q <= pwdata[7:0];
        gmt_pkg::RegRemoveDelay: remove_delay_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gmt_pkg::RegSelfId:      prdata = self_id_q;
      gmt_pkg::RegSelfPort:    prdata = {16'd0, self_port_q};
      gmt_pkg::RegFailTimeout: prdata = {24'd0, fail_timeout_q};
      gmt_pkg::RegRemoveDelay: prdata = {24'd0, remove_delay_q};
      default:                 prdata = '0;
    endcase
  end

  gmt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .out_valid_o, .out_ready_i, .last_o, .done_sel_o(done_sel),
    .cmd_o(cmd), .sts_i(sts)
  );

  gmt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .func_i, .member_id_i,
    .member_port_i, .member_heartbeat_i,
    .self_id_i(self_id_q), .self_port_i(self_port_q),
    .fail_timeout_i(fail_timeout_q), .remove_delay_i(remove_delay_q),
    .res_kind_o(res_kind), .res_id_o(res_id), .res_port_o(res_port),
    .res_heartbeat_o(res_hb), .local_hb_o(local_hb)
  );

  // done beat carries zero id and port and the local heartbeat
  assign kind_o = done_sel ? gmt_pkg::KindDone : res_kind;
  assign out_id_o = done_sel ? 32'd0 : res_id;
  assign out_port_o = done_sel ? 16'd0 : res_port;
  assign out_heartbeat_o = done_sel ? local_hb : res_hb;

`ifndef SYNTH
  // no new item while a result is still pending
  a_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (!out_valid_o || out_ready_i))
    else $error("input taken while output blocked");
  // the done beat is always the last one
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == gmt_pkg::KindDone) |-> last_o)
    else $error("done beat without last");
  // an accepted item does not leave the block ready on the next edge
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");
`endif
endmodule
